### rtl/core/video_frame_presentation_queue_defines.svh
// Assertion macros for the video frame presentation queue.
`ifndef VIDEO_FRAME_PRESENTATION_QUEUE_DEFINES_SVH
`define VIDEO_FRAME_PRESENTATION_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define VFPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VFPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VFPQ_ASSERT_IMP(lbl, ante, cons, msg)
`define VFPQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/vfpq_pkg.sv
// Shared types and constants of the video frame presentation queue.
package vfpq_pkg;

  localparam int FUNC_W    = 3;
  localparam int HANDLE_W  = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 4;
  localparam int DROP_W    = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_STATUS = 3'd0,
    FUNC_QUERY  = 3'd1,
    FUNC_SEEK   = 3'd2,
    FUNC_EOS    = 3'd3,
    FUNC_SAMPLE = 3'd4
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CACHED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREROLL    = 4'd1;

  localparam logic [CFG_W-1:0] MAX_CACHED_RST = 5'd12;
  localparam logic [CFG_W-1:0] PREROLL_RST    = 5'd8;

endpackage

### rtl/core/vfpq_mem.sv
// Frame queue storage: one write port, one read port with registered read data.
module vfpq_mem #(
  parameter int DEPTH = 16,
  parameter int DATA_W = 65,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AddrW-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/video_frame_presentation_queue.sv
// Video frame presentation queue: frame FIFO with seek preroll and display pop.
//
// Input channel (in_valid/in_stall) carries one command item: decoder status,
// display query, seek, end-of-stream write or sample write. Each item yields
// exactly one status item on the output channel (out_valid/out_stall).
// The block works on one item at a time; in_stall is high from acceptance
// until the result is loaded into the output register.
// Each command goes from acceptance through ST_EXEC to ST_OUT, where its
// result is loaded; a display query on a non-empty queue passes through
// ST_CMP between them and stays there while frames are popped. The pop loop
// walks the frame memory one entry per cycle through its registered read port.
// A new item is accepted the cycle after the previous result is loaded, so the
// block never takes a new item before the last one is through.
// The output register frees the core: a stalled result holds, and the block
// finishes the next item up to the load, waiting only while out_valid is high
// and out_stall is asserted.
// Configuration (cfg_valid/cfg_ready, always ready) writes max_cached_frames
// at index 0 and preroll_frames at index 1; write only while idle.
// Reset (rst_n low, synchronous) empties the queue, clears seek, end of stream
// and drop count, and restores the register defaults 12 and 8.
`include "video_frame_presentation_queue_defines.svh"

module video_frame_presentation_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [vfpq_pkg::FUNC_W-1:0]           in_func,
  input  logic                                  in_has_frame,
  input  logic [vfpq_pkg::HANDLE_W-1:0]         in_frame_handle,
  input  logic [TIME_WIDTH-1:0]                 in_frame_pts,
  input  logic                                  in_frame_is_eos,
  input  logic                                  in_decoder_needs_input,
  input  logic [TIME_WIDTH-1:0]                 in_query_time,
  input  logic [TIME_WIDTH-1:0]                 in_seek_time,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_shown_valid,
  output logic [vfpq_pkg::HANDLE_W-1:0]         out_shown_handle,
  output logic                                  out_shown_is_eos,
  output logic [vfpq_pkg::DROP_W-1:0]           out_dropped_count,
  output logic                                  out_can_accept,
  output logic                                  out_eos_played,
  output logic                                  out_seek_active,
  output logic                                  out_sample_rejected,
  output logic                                  out_queue_overflow,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vfpq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vfpq_pkg::CFG_W-1:0]            cfg_data
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int CMP_W   = (CNT_W > vfpq_pkg::CFG_W) ? CNT_W : vfpq_pkg::CFG_W;
  localparam int ENTRY_W = TIME_WIDTH + vfpq_pkg::HANDLE_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);
  localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  vfpq_pkg::func_t                 func_r;
  logic                            has_frame_r;
  logic [vfpq_pkg::HANDLE_W-1:0]   handle_r;
  logic [TIME_WIDTH-1:0]           pts_r;
  logic                            fr_eos_r;
  logic                            needs_r;
  logic [TIME_WIDTH-1:0]           qtime_r;
  logic [TIME_WIDTH-1:0]           stime_r;

  // queue and player state
  logic [ADDR_W-1:0]               head_r, head_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            last_valid_r, last_valid_nxt;
  logic [vfpq_pkg::HANDLE_W-1:0]   last_handle_r, last_handle_nxt;
  logic                            last_eos_r, last_eos_nxt;
  logic                            shown_r, shown_nxt;
  logic                            seeking_r, seeking_nxt;
  logic [TIME_WIDTH-1:0]           target_r, target_nxt;
  logic                            eos_wr_r, eos_wr_nxt;
  logic                            wants_r, wants_nxt;
  logic [vfpq_pkg::DROP_W-1:0]     drop_r, drop_nxt;
  logic                            rejected_r, rejected_nxt;
  logic                            overflow_r, overflow_nxt;
  logic [vfpq_pkg::CFG_W-1:0]      max_cached_r;
  logic [vfpq_pkg::CFG_W-1:0]      preroll_r;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_load;
  logic                            sh_valid_r;
  logic [vfpq_pkg::HANDLE_W-1:0]   sh_handle_r;
  logic                            sh_eos_r;
  logic [vfpq_pkg::DROP_W-1:0]     sh_drop_r;
  logic                            sh_accept_r;
  logic                            sh_played_r;
  logic                            sh_seek_r;
  logic                            sh_rej_r;
  logic                            sh_ovf_r;

  // memory port
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [ENTRY_W-1:0]              mem_wdata;
  logic [ADDR_W-1:0]               mem_raddr;
  logic [ENTRY_W-1:0]              mem_rdata;
  logic [TIME_WIDTH-1:0]           rd_time;
  logic [vfpq_pkg::HANDLE_W-1:0]   rd_handle;
  logic                            rd_eos;

  logic                            accept;
  logic                            too_early;
  logic                            seek_keep;
  logic                            full;
  logic                            do_push;
  logic [CNT_W-1:0]                cnt_push;
  logic                            preroll_hit;
  logic [SUM_W-1:0]                slot_sum;
  logic [SUM_W-1:0]                slot_wrap;
  logic [ADDR_W-1:0]               head_inc;
  logic                            pop;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign {rd_eos, rd_handle, rd_time} = mem_rdata;

  vfpq_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    too_early   = seeking_r && !fr_eos_r && ($signed(pts_r) < $signed(target_r));
    seek_keep   = seeking_r && !fr_eos_r;
    full        = (count_r >= DEPTH_CNT);
    do_push     = !too_early && !full;
    cnt_push    = do_push ? count_r + ONE_CNT : count_r;
    preroll_hit = (CMP_W'(cnt_push) >= CMP_W'(preroll_r));
    slot_sum    = SUM_W'(head_r) + SUM_W'(count_r);
    slot_wrap   = (slot_sum >= DEPTH_SUM) ? slot_sum - DEPTH_SUM : slot_sum;
    head_inc    = (head_r == LAST_ADDR) ? '0 : head_r + ADDR_W'(1);
    pop         = (count_r > ONE_CNT) && ($signed(rd_time) < $signed(qtime_r));
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    last_valid_nxt  = last_valid_r;
    last_handle_nxt = last_handle_r;
    last_eos_nxt    = last_eos_r;
    shown_nxt       = shown_r;
    seeking_nxt     = seeking_r;
    target_nxt      = target_r;
    eos_wr_nxt      = eos_wr_r;
    wants_nxt       = wants_r;
    drop_nxt        = drop_r;
    rejected_nxt    = rejected_r;
    overflow_nxt    = overflow_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = slot_wrap[ADDR_W-1:0];
    mem_wdata       = {fr_eos_r, handle_r, pts_r};
    mem_raddr       = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rejected_nxt = 1'b0;
        overflow_nxt = 1'b0;
        state_nxt    = ST_OUT;
        unique case (func_r)
          vfpq_pkg::FUNC_STATUS: begin
            if (has_frame_r) begin
              seeking_nxt = seek_keep;
              if (!too_early) begin
                if (full) begin
                  overflow_nxt = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = cnt_push;
                  if (count_r == '0) begin
                    shown_nxt = 1'b0;
                  end
                end
              end
              if (seek_keep && preroll_hit) begin
                seeking_nxt = 1'b0;
              end
            end
            wants_nxt = needs_r;
          end
          vfpq_pkg::FUNC_QUERY: begin
            if (count_r != '0) begin
              state_nxt = ST_CMP;
            end
          end
          vfpq_pkg::FUNC_SEEK: begin
            target_nxt  = stime_r[TIME_WIDTH-1] ? '0 : stime_r;
            seeking_nxt = 1'b1;
            eos_wr_nxt  = 1'b0;
            head_nxt    = '0;
            count_nxt   = '0;
            shown_nxt   = 1'b0;
          end
          vfpq_pkg::FUNC_EOS: begin
            eos_wr_nxt = 1'b1;
          end
          vfpq_pkg::FUNC_SAMPLE: begin
            if (eos_wr_r) begin
              rejected_nxt = 1'b1;
            end else begin
              wants_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_CMP: begin
        if (pop) begin
          if (!shown_r) begin
            drop_nxt = drop_r + 32'd1;
          end
          head_nxt  = head_inc;
          count_nxt = count_r - ONE_CNT;
          shown_nxt = 1'b0;
          mem_raddr = head_inc;
        end else begin
          last_valid_nxt  = 1'b1;
          last_handle_nxt = rd_handle;
          last_eos_nxt    = rd_eos;
          shown_nxt       = 1'b1;
          state_nxt       = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      last_valid_r  <= 1'b0;
      last_handle_r <= '0;
      last_eos_r    <= 1'b0;
      shown_r       <= 1'b0;
      seeking_r     <= 1'b0;
      target_r      <= '0;
      eos_wr_r      <= 1'b0;
      wants_r       <= 1'b1;
      drop_r        <= '0;
      rejected_r    <= 1'b0;
      overflow_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      last_valid_r  <= last_valid_nxt;
      last_handle_r <= last_handle_nxt;
      last_eos_r    <= last_eos_nxt;
      shown_r       <= shown_nxt;
      seeking_r     <= seeking_nxt;
      target_r      <= target_nxt;
      eos_wr_r      <= eos_wr_nxt;
      wants_r       <= wants_nxt;
      drop_r        <= drop_nxt;
      rejected_r    <= rejected_nxt;
      overflow_r    <= overflow_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cached_r <= vfpq_pkg::MAX_CACHED_RST;
      preroll_r    <= vfpq_pkg::PREROLL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vfpq_pkg::CFG_MAX_CACHED: max_cached_r <= cfg_data;
        vfpq_pkg::CFG_PREROLL:    preroll_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r      <= vfpq_pkg::func_t'(in_func);
      has_frame_r <= in_has_frame;
      handle_r    <= in_frame_handle;
      pts_r       <= in_frame_pts;
      fr_eos_r    <= in_frame_is_eos;
      needs_r     <= in_decoder_needs_input;
      qtime_r     <= in_query_time;
      stime_r     <= in_seek_time;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sh_valid_r  <= last_valid_r;
      sh_handle_r <= last_valid_r ? last_handle_r : '0;
      sh_eos_r    <= last_valid_r && last_eos_r;
      sh_drop_r   <= drop_r;
      sh_accept_r <= (CMP_W'(count_r) < CMP_W'(max_cached_r)) && !eos_wr_r && wants_r;
      sh_played_r <= eos_wr_r && (count_r <= ONE_CNT);
      sh_seek_r   <= seeking_r;
      sh_rej_r    <= rejected_r;
      sh_ovf_r    <= overflow_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_shown_valid     = sh_valid_r;
  assign out_shown_handle    = sh_handle_r;
  assign out_shown_is_eos    = sh_eos_r;
  assign out_dropped_count   = sh_drop_r;
  assign out_can_accept      = sh_accept_r;
  assign out_eos_played      = sh_played_r;
  assign out_seek_active     = sh_seek_r;
  assign out_sample_rejected = sh_rej_r;
  assign out_queue_overflow  = sh_ovf_r;

  `VFPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_CNT, "queue count above depth")
  `VFPQ_ASSERT_IMP(a_cmp_nonempty, state_r == ST_CMP, count_r != '0, "pop walk on empty queue")
  `VFPQ_ASSERT_NXT(a_accept_exec, accept, state_r == ST_EXEC, "accepted item not executed")
  `VFPQ_ASSERT_NXT(a_drop_in_cmp, state_r != ST_CMP, drop_r == $past(drop_r), "drop count moved")
  `VFPQ_ASSERT_NXT(a_out_load, out_load, out_valid_r && state_r == ST_IDLE, "result not loaded")

endmodule

### sim/tb.sv
// Self-checking testbench for video_frame_presentation_queue with a built-in frame queue model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int TW           = 48;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_PCT     = 19;
  localparam int N_SETTINGS   = 6;

  typedef logic [vfpq_pkg::FUNC_W-1:0]   func_code_t;
  typedef logic [vfpq_pkg::HANDLE_W-1:0] handle_t;

  localparam func_code_t FUNC_RSVD_LO = 3'd5;
  localparam func_code_t FUNC_RSVD_HI = 3'd7;
  localparam logic [vfpq_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'hf;

  typedef logic signed [TW-1:0] stamp_t;
  localparam stamp_t STAMP_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam stamp_t STAMP_MAX = {1'b0, {(TW-1){1'b1}}};

  typedef struct {
    func_code_t func;
    logic       has_frame;
    handle_t    handle;
    stamp_t     pts;
    logic       is_eos;
    logic       needs_input;
    stamp_t     query_time;
    stamp_t     seek_time;
  } cmd_t;

  typedef struct {
    logic                          shown_valid;
    handle_t                       shown_handle;
    logic                          shown_is_eos;
    logic [vfpq_pkg::DROP_W-1:0]   dropped;
    logic                          can_accept;
    logic                          eos_played;
    logic                          seek_active;
    logic                          rejected;
    logic                          overflow;
  } status_t;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  func_code_t                        in_func = '0;
  logic                              in_has_frame = 1'b0;
  handle_t                           in_frame_handle = '0;
  logic [TW-1:0]                     in_frame_pts = '0;
  logic                              in_frame_is_eos = 1'b0;
  logic                              in_decoder_needs_input = 1'b0;
  logic [TW-1:0]                     in_query_time = '0;
  logic [TW-1:0]                     in_seek_time = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_shown_valid;
  handle_t                           out_shown_handle;
  logic                              out_shown_is_eos;
  logic [vfpq_pkg::DROP_W-1:0]       out_dropped_count;
  logic                              out_can_accept;
  logic                              out_eos_played;
  logic                              out_seek_active;
  logic                              out_sample_rejected;
  logic                              out_queue_overflow;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [vfpq_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [vfpq_pkg::CFG_W-1:0]        cfg_data = '0;

  video_frame_presentation_queue #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_WIDTH(TW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_has_frame(in_has_frame),
    .in_frame_handle(in_frame_handle),
    .in_frame_pts(in_frame_pts),
    .in_frame_is_eos(in_frame_is_eos),
    .in_decoder_needs_input(in_decoder_needs_input),
    .in_query_time(in_query_time),
    .in_seek_time(in_seek_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_shown_valid(out_shown_valid),
    .out_shown_handle(out_shown_handle),
    .out_shown_is_eos(out_shown_is_eos),
    .out_dropped_count(out_dropped_count),
    .out_can_accept(out_can_accept),
    .out_eos_played(out_eos_played),
    .out_seek_active(out_seek_active),
    .out_sample_rejected(out_sample_rejected),
    .out_queue_overflow(out_queue_overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // frame queue model state
  handle_t                     q_handle [DEPTH];
  stamp_t                      q_pts [DEPTH];
  logic                        q_eos [DEPTH];
  int unsigned                 q_head;
  int unsigned                 q_count;
  logic                        shown_v;
  handle_t                     shown_h;
  logic                        shown_e;
  logic                        head_shown;
  logic                        seeking;
  stamp_t                      seek_at;
  logic                        eos_seen;
  logic                        decoder_hungry;
  logic [vfpq_pkg::DROP_W-1:0] drops;
  logic [vfpq_pkg::CFG_W-1:0]  cache_limit;
  logic [vfpq_pkg::CFG_W-1:0]  preroll_need;

  cmd_t    pending[$];
  cmd_t    offered;
  status_t expected_status[$];

  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_overflow = 0;
  int n_rejected = 0;
  int n_shown_eos = 0;

  logic [vfpq_pkg::CFG_W-1:0] set_cache [N_SETTINGS] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd12};
  logic [vfpq_pkg::CFG_W-1:0] set_pre   [N_SETTINGS] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8};

  function automatic status_t present_step(cmd_t c);
    status_t     r;
    logic        skip;
    int unsigned slot;
    r.rejected = 1'b0;
    r.overflow = 1'b0;
    case (c.func)
      vfpq_pkg::FUNC_STATUS: begin
        if (c.has_frame) begin
          skip = 1'b0;
          if (seeking) begin
            if (c.is_eos) seeking = 1'b0;
            else if (c.pts < seek_at) skip = 1'b1;
          end
          if (!skip) begin
            if (q_count >= DEPTH) begin
              r.overflow = 1'b1;
            end else begin
              slot = (q_head + q_count) % DEPTH;
              q_handle[slot] = c.handle;
              q_pts[slot] = c.pts;
              q_eos[slot] = c.is_eos;
              if (q_count == 0) head_shown = 1'b0;
              q_count++;
            end
          end
          if (seeking && q_count >= preroll_need) seeking = 1'b0;
        end
        decoder_hungry = c.needs_input;
      end
      vfpq_pkg::FUNC_QUERY: begin
        if (q_count > 0) begin
          while (q_count > 1 && q_pts[q_head] < c.query_time) begin
            if (!head_shown) drops++;
            q_head = (q_head + 1) % DEPTH;
            q_count--;
            head_shown = 1'b0;
          end
          shown_v = 1'b1;
          shown_h = q_handle[q_head];
          shown_e = q_eos[q_head];
          head_shown = 1'b1;
        end
      end
      vfpq_pkg::FUNC_SEEK: begin
        seek_at = c.seek_time[TW-1] ? '0 : c.seek_time;
        seeking = 1'b1;
        eos_seen = 1'b0;
        q_head = 0;
        q_count = 0;
        head_shown = 1'b0;
      end
      vfpq_pkg::FUNC_EOS: eos_seen = 1'b1;
      vfpq_pkg::FUNC_SAMPLE: begin
        if (eos_seen) r.rejected = 1'b1;
        else decoder_hungry = 1'b0;
      end
      default: ;
    endcase
    r.shown_valid  = shown_v;
    r.shown_handle = shown_v ? shown_h : '0;
    r.shown_is_eos = shown_v && shown_e;
    r.dropped      = drops;
    r.can_accept   = (q_count < cache_limit) && !eos_seen && decoder_hungry;
    r.eos_played   = eos_seen && (q_count <= 1);
    r.seek_active  = seeking;
    return r;
  endfunction

  function automatic stamp_t rand_stamp();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TW-1:0];
  endfunction

  function automatic cmd_t make_cmd(func_code_t f);
    cmd_t c;
    c.func        = f;
    c.has_frame   = 1'($urandom_range(1));
    c.handle      = handle_t'($urandom());
    c.pts         = rand_stamp();
    c.is_eos      = 1'($urandom_range(1));
    c.needs_input = 1'($urandom_range(1));
    c.query_time  = rand_stamp();
    c.seek_time   = rand_stamp();
    return c;
  endfunction

  function automatic cmd_t frame_cmd(handle_t h, stamp_t t, logic e, logic need);
    cmd_t c;
    c = make_cmd(vfpq_pkg::FUNC_STATUS);
    c.has_frame   = 1'b1;
    c.handle      = h;
    c.pts         = t;
    c.is_eos      = e;
    c.needs_input = need;
    return c;
  endfunction

  function automatic cmd_t query_cmd(stamp_t t);
    cmd_t c;
    c = make_cmd(vfpq_pkg::FUNC_QUERY);
    c.query_time = t;
    return c;
  endfunction

  function automatic cmd_t seek_cmd(stamp_t t);
    cmd_t c;
    c = make_cmd(vfpq_pkg::FUNC_SEEK);
    c.seek_time = t;
    return c;
  endfunction

  function automatic void add_cmd(cmd_t c);
    pending = {pending, c};
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_status.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status = {expected_status, present_step(offered)};
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          offered = pending[0];
          pending.delete(0);
          in_valid <= 1'b1;
          in_func <= offered.func;
          in_has_frame <= offered.has_frame;
          in_frame_handle <= offered.handle;
          in_frame_pts <= offered.pts;
          in_frame_is_eos <= offered.is_eos;
          in_decoder_needs_input <= offered.needs_input;
          in_query_time <= offered.query_time;
          in_seek_time <= offered.seek_time;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // status monitor
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report("status item with none pending", 64'(out_valid), 64'd0);
      end else begin
        want = expected_status[0];
        expected_status.delete(0);
        n_checked++;
        if (want.overflow) n_overflow++;
        if (want.rejected) n_rejected++;
        if (want.shown_is_eos) n_shown_eos++;
        check_field("shown_valid", 64'(out_shown_valid), 64'(want.shown_valid));
        check_field("shown_handle", 64'(out_shown_handle), 64'(want.shown_handle));
        check_field("shown_is_eos", 64'(out_shown_is_eos), 64'(want.shown_is_eos));
        check_field("dropped_count", 64'(out_dropped_count), 64'(want.dropped));
        check_field("can_accept", 64'(out_can_accept), 64'(want.can_accept));
        check_field("eos_played", 64'(out_eos_played), 64'(want.eos_played));
        check_field("seek_active", 64'(out_seek_active), 64'(want.seek_active));
        check_field("sample_rejected", 64'(out_sample_rejected), 64'(want.rejected));
        check_field("queue_overflow", 64'(out_queue_overflow), 64'(want.overflow));
      end
    end
  end

  task automatic write_reg(logic [vfpq_pkg::CFG_IDX_W-1:0] idx,
                           logic [vfpq_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == vfpq_pkg::CFG_MAX_CACHED) cache_limit = val;
    else if (idx == vfpq_pkg::CFG_PREROLL) preroll_need = val;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while ((pending.size() != 0 || in_valid || expected_status.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_status.size() != 0 || pending.size() != 0) begin
      report("status items missing", 64'(expected_status.size()), 64'd0);
      expected_status.delete();
      pending.delete();
    end
    repeat (24) @(negedge clk);
  endtask

  task automatic random_run(int n);
    cmd_t   c;
    stamp_t clock_pos;
    stamp_t play_pos;
    stamp_t target;
    int     left;
    int     len;
    int     r;
    bit     burst;
    left = n;
    while (left > 0) begin
      clock_pos = stamp_t'($urandom_range(200000)) - stamp_t'(20000);
      target = ($urandom_range(7) == 0) ? rand_stamp()
                                        : clock_pos + stamp_t'($urandom_range(9000));
      play_pos = target;
      add_cmd(seek_cmd(target));
      left--;
      burst = ($urandom_range(4) == 0);
      len = burst ? int'($urandom_range(14, 24)) : int'($urandom_range(4, 40));
      for (int i = 0; i < len && left > 0; i++) begin
        r = burst ? int'($urandom_range(44)) : int'($urandom_range(99));
        if (r < 45) begin
          add_cmd(frame_cmd(handle_t'($urandom()), clock_pos, $urandom_range(49) == 0,
                            $urandom_range(99) < 70));
          if (r < 2) clock_pos = clock_pos - stamp_t'(3000);
          else clock_pos = clock_pos + stamp_t'($urandom_range(3000));
          left--;
        end else if (r < 55) begin
          c = make_cmd(vfpq_pkg::FUNC_STATUS);
          c.has_frame = 1'b0;
          add_cmd(c);
          left--;
        end else if (r < 75) begin
          play_pos = play_pos + stamp_t'($urandom_range(6000));
          add_cmd(query_cmd(play_pos));
          left--;
        end else if (r < 82) begin
          add_cmd(make_cmd(vfpq_pkg::FUNC_SAMPLE));
          left--;
        end else if (r < 85) begin
          add_cmd(make_cmd(vfpq_pkg::FUNC_EOS));
          left--;
        end else if (r < 93) begin
          c = make_cmd(func_code_t'($urandom_range(FUNC_RSVD_HI)));
          add_cmd(c);
          if (c.func <= vfpq_pkg::FUNC_SAMPLE) left--;
        end else begin
          c = make_cmd($urandom_range(1) ? vfpq_pkg::FUNC_QUERY : vfpq_pkg::FUNC_STATUS);
          add_cmd(c);
          left--;
        end
      end
    end
  endtask

  initial begin
    cmd_t c;
    q_head = 0;
    q_count = 0;
    shown_v = 1'b0;
    shown_h = '0;
    shown_e = 1'b0;
    head_shown = 1'b0;
    seeking = 1'b0;
    seek_at = '0;
    eos_seen = 1'b0;
    decoder_hungry = 1'b1;
    drops = '0;
    cache_limit = vfpq_pkg::MAX_CACHED_RST;
    preroll_need = vfpq_pkg::PREROLL_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset register values
    add_cmd(query_cmd('0));
    c = make_cmd(vfpq_pkg::FUNC_STATUS);
    c.has_frame = 1'b0;
    c.needs_input = 1'b0;
    add_cmd(c);
    add_cmd(make_cmd(FUNC_RSVD_LO));
    add_cmd(make_cmd(FUNC_RSVD_HI));
    add_cmd(frame_cmd(16'h0000, STAMP_MIN, 1'b0, 1'b1));
    add_cmd(frame_cmd(16'hffff, STAMP_MAX, 1'b0, 1'b1));
    add_cmd(query_cmd('0));
    add_cmd(query_cmd(STAMP_MIN));
    add_cmd(seek_cmd(STAMP_MIN));
    add_cmd(frame_cmd(16'h1234, stamp_t'(-5), 1'b0, 1'b1));
    add_cmd(frame_cmd(16'h2345, '0, 1'b0, 1'b1));
    add_cmd(frame_cmd(16'h3456, stamp_t'(-100), 1'b1, 1'b1));
    add_cmd(query_cmd(STAMP_MAX));
    add_cmd(make_cmd(vfpq_pkg::FUNC_EOS));
    add_cmd(make_cmd(vfpq_pkg::FUNC_EOS));
    add_cmd(make_cmd(vfpq_pkg::FUNC_SAMPLE));
    add_cmd(seek_cmd(stamp_t'(1000)));
    add_cmd(make_cmd(vfpq_pkg::FUNC_SAMPLE));
    for (int i = 0; i < 8; i++)
      add_cmd(frame_cmd(handle_t'(16'h4000 + i), stamp_t'(900 + 100 * i), 1'b0, 1'b1));
    add_cmd(query_cmd(stamp_t'(1450)));
    drain();
    random_run(60);
    drain();

    for (int p = 0; p < N_SETTINGS; p++) begin
      write_reg(vfpq_pkg::CFG_MAX_CACHED, set_cache[p]);
      write_reg(vfpq_pkg::CFG_PREROLL, set_pre[p]);
      if (p == 2) write_reg(CFG_UNUSED, 5'h1f);
      @(negedge clk);
      quiet = (p == 1);
      if (p == 4) hold_req++;
      random_run(110);
      drain();
      quiet = 1'b0;
    end

    $display("covered %0d items over %0d register settings, %0d status items checked",
             n_accepted, N_SETTINGS + 1, n_checked);
    $display("refused pushes %0d, rejected samples %0d, eos frames shown %0d, drops %0d",
             n_overflow, n_rejected, n_shown_eos, drops);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
